// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// File: rtl/core/desrk_pkg.sv
package desrk_pkg;

   localparam int KEY_BITS      = 64;
   localparam int HALF_KEY_BITS = 28;
   localparam int JOINED_BITS   = 56;
   localparam int SUBKEY_BITS   = 48;
   localparam int ROUND_COUNT   = 16;
   localparam int ROUND_BITS    = 4;
   localparam int SHIFT_BITS    = 5;

   // Stream widths, padded to whole bytes
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 56;

   typedef logic [KEY_BITS-1:0]      key_type;
   typedef logic [HALF_KEY_BITS-1:0] half_type;
   typedef logic [SUBKEY_BITS-1:0]   subkey_type;
   typedef logic [ROUND_BITS-1:0]    round_type;
   typedef logic [SHIFT_BITS-1:0]    shift_type;

   // PC-1 selection for the C and D halves (bit 1 is the MSB)
   localparam logic [6:0] PC1_C [HALF_KEY_BITS] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
      7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
      7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36
   };

   localparam logic [6:0] PC1_D [HALF_KEY_BITS] = '{
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54,
      7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   // PC-2 selection from C||D
   localparam logic [5:0] PC2_MAP [SUBKEY_BITS] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
      6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
      6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
      6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
      6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   // Cumulative left rotation of each half per round
   localparam logic [SHIFT_BITS-1:0] TOTAL_SHIFT [ROUND_COUNT] = '{
      5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
      5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
   };

   // Gather one PC-1 half from the key
   function automatic half_type pc1_half(input key_type key, input logic pick_d);
      half_type r;
      r = '0;
      for (int i = 0; i < HALF_KEY_BITS; i++) begin
         if (pick_d) begin
            r[HALF_KEY_BITS-1-i] = key[KEY_BITS - int'(PC1_D[i])];
         end else begin
            r[HALF_KEY_BITS-1-i] = key[KEY_BITS - int'(PC1_C[i])];
         end
      end
      return r;
   endfunction

   // Rotate a half left by 0..28 places
   function automatic half_type rotate_half(input half_type v, input shift_type s);
      logic [2*HALF_KEY_BITS-1:0] dbl;
      dbl = {v, v} << s;
      return dbl[2*HALF_KEY_BITS-1:HALF_KEY_BITS];
   endfunction

   // Select the subkey bits from C||D
   function automatic subkey_type pc2(input logic [JOINED_BITS-1:0] joined);
      subkey_type r;
      r = '0;
      for (int i = 0; i < SUBKEY_BITS; i++) begin
         r[SUBKEY_BITS-1-i] = joined[JOINED_BITS - int'(PC2_MAP[i])];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/desrk_subkey.sv
module desrk_subkey
   import desrk_pkg::*;
(
   input  key_type    cipher_key,
   input  round_type  round_number,
   output subkey_type round_subkey
);

   half_type  c_half;
   half_type  d_half;
   half_type  c_rot;
   half_type  d_rot;
   shift_type shift_amt;

   // Split the key, rotate both halves, compress
   always_comb begin
      shift_amt    = TOTAL_SHIFT[round_number];
      c_half       = pc1_half(cipher_key, 1'b0);
      d_half       = pc1_half(cipher_key, 1'b1);
      c_rot        = rotate_half(c_half, shift_amt);
      d_rot        = rotate_half(d_half, shift_amt);
      round_subkey = pc2({c_rot, d_rot});
   end

endmodule

// File: rtl/core/des_round_key_generator.sv
// DES key schedule: each transfer carries a 64-bit key and a round number 0..15,
// and the block returns that round's 48-bit subkey (PC-1, cumulative left
// rotation of both halves, PC-2; bit 1 is the MSB, parity bits are ignored)
// together with the round number. A new key can be taken every cycle while the
// result is not stalled, so one subkey per cycle is sustained. A request passes
// through the input register, then the permutation logic, and then the result
// register before it is offered. A stalled result holds in the result register
// while one more input is still taken into the input register.
module des_round_key_generator
   import desrk_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [63:0] cipher_key, [67:64] round_number, [71:68] zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [47:0] round_subkey, [51:48] round_echo, [55:52] zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   `include "assert_macros.svh"

   logic       s1_valid_ff;
   logic       s1_valid_in;
   key_type    s1_key_ff;
   round_type  s1_round_ff;
   logic       s2_valid_ff;
   logic       s2_valid_in;
   subkey_type s2_subkey_ff;
   round_type  s2_round_ff;
   subkey_type subkey;
   logic       s2_load;
   logic       req_take;

   desrk_subkey u_subkey (
      .cipher_key   (s1_key_ff),
      .round_number (s1_round_ff),
      .round_subkey (subkey)
   );

   // Advance when the next stage is free or drains this cycle
   always_comb begin
      s2_load     = !s2_valid_ff || rsp_tready;
      req_tready  = !s1_valid_ff || s2_load;
      req_take    = req_tvalid && req_tready;
      s1_valid_in = req_take || (s1_valid_ff && !s2_load);
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_key_ff   <= req_tdata[KEY_BITS-1:0];
         s1_round_ff <= req_tdata[KEY_BITS +: ROUND_BITS];
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         s2_subkey_ff <= subkey;
         s2_round_ff  <= s1_round_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-SUBKEY_BITS-ROUND_BITS){1'b0}},
                        s2_round_ff, s2_subkey_ff};

   `ASSERT_NEXT(a_fill_result, clock, reset, s1_valid_ff && s2_load, rsp_tvalid)
   `ASSERT_SAME(a_hold_input, clock, reset, s1_valid_ff && rsp_tvalid && !rsp_tready,
      !req_tready)
   `ASSERT_NEXT(a_round_echo, clock, reset, s1_valid_ff && s2_load,
      rsp_tdata[SUBKEY_BITS +: ROUND_BITS] == $past(s1_round_ff))

endmodule
